@@ hw/rtl/cntd_pkg.sv @@
// Shared types and constants for the Chinese numeral to decimal converter.
// No dependencies; imported by every module of the block.
package cntd_pkg;

   localparam int unsigned SymbolWidth = 4;
   localparam int unsigned DigitWidth  = 4;
   localparam int unsigned MaxDigits   = 8;
   localparam int unsigned CountWidth  = $clog2(MaxDigits + 1);

   localparam logic [SymbolWidth-1:0] SymZero     = 4'd0;
   localparam logic [SymbolWidth-1:0] SymTen      = 4'd10;
   localparam logic [SymbolWidth-1:0] SymThousand = 4'd12;
   localparam logic [SymbolWidth-1:0] SymMyriad   = 4'd13;
   localparam logic [SymbolWidth-1:0] UnitNine    = 4'd9;

   typedef struct packed {
      logic [SymbolWidth-1:0] symbol;
      logic                   last_symbol;
   } req_word_type;

   typedef struct packed {
      logic [DigitWidth-1:0] digit;
      logic                  digit_valid;
      logic                  end_of_number;
   } rsp_word_type;

   // Digits of one symbol step, lowest index leaves first.
   typedef struct packed {
      logic [MaxDigits-1:0][DigitWidth-1:0] digits;
      logic [CountWidth-1:0]                count;
      logic                                 last;
      logic                                 bare;
   } pkt_type;

endpackage

@@ hw/rtl/cntd_core.sv @@
// Numeral state registers and the per-symbol digit expansion logic.
// Depends on cntd_pkg.
module cntd_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  cntd_pkg::req_word_type word,
   output cntd_pkg::pkt_type     pkt
);
   import cntd_pkg::*;

   logic                   zero_pending_ff, zero_pending_in;
   logic                   at_start_ff, at_start_in;
   logic [SymbolWidth-1:0] last_unit_ff, last_unit_in;
   logic [DigitWidth-1:0]  deferred_ff, deferred_in;
   logic                   any_emitted_ff, any_emitted_in;

   always_comb begin
      logic [MaxDigits-1:0][DigitWidth-1:0] dig;
      logic [CountWidth-1:0]                cnt;
      logic [SymbolWidth-1:0]               sym;
      logic [SymbolWidth-1:0]               nz;
      logic                                 last;
      sym = word.symbol;
      last = word.last_symbol;
      dig = '0;
      cnt = '0;
      nz = '0;
      zero_pending_in = zero_pending_ff;
      at_start_in = at_start_ff;
      last_unit_in = last_unit_ff;
      deferred_in = deferred_ff;
      any_emitted_in = any_emitted_ff;

      // a held zero becomes one when a ten follows it
      if (zero_pending_in) begin
         zero_pending_in = 1'b0;
         if (sym == SymTen) begin
            if (last_unit_in <= SymTen) begin
               if (cnt < CountWidth'(MaxDigits)) begin
                  dig[cnt[$clog2(MaxDigits)-1:0]] = DigitWidth'(1);
                  cnt = cnt + 1'b1;
               end
               any_emitted_in = 1'b1;
               last_unit_in = '0;
            end else begin
               deferred_in = DigitWidth'(1);
            end
         end
      end

      if (sym == SymZero) begin
         if (!last) zero_pending_in = 1'b1;
      end else if (at_start_in && sym == SymTen) begin
         if (cnt < CountWidth'(MaxDigits)) begin
            dig[cnt[$clog2(MaxDigits)-1:0]] = DigitWidth'(1);
            cnt = cnt + 1'b1;
         end
         any_emitted_in = 1'b1;
         last_unit_in = SymTen;
         deferred_in = '0;
      end else if (sym < SymTen) begin
         if (last_unit_in <= SymTen) begin
            if (cnt < CountWidth'(MaxDigits)) begin
               dig[cnt[$clog2(MaxDigits)-1:0]] = sym;
               cnt = cnt + 1'b1;
            end
            any_emitted_in = 1'b1;
            last_unit_in = '0;
         end else begin
            deferred_in = sym;
         end
      end else if (sym <= SymThousand) begin
         // ten, hundred, thousand: fill skipped places, then the held digit
         if (last_unit_in > sym + 1'b1) nz = last_unit_in - sym - 1'b1;
         for (int k = 0; k < 4; k++) begin
            if (SymbolWidth'(k) < nz) begin
               if (cnt < CountWidth'(MaxDigits)) begin
                  dig[cnt[$clog2(MaxDigits)-1:0]] = '0;
                  cnt = cnt + 1'b1;
               end
               any_emitted_in = 1'b1;
            end
         end
         if (last_unit_in != '0) begin
            if (cnt < CountWidth'(MaxDigits)) begin
               dig[cnt[$clog2(MaxDigits)-1:0]] = deferred_in;
               cnt = cnt + 1'b1;
            end
            any_emitted_in = 1'b1;
         end
         last_unit_in = sym;
         deferred_in = '0;
      end else if (sym == SymMyriad) begin
         if (last_unit_in >= SymTen) nz = last_unit_in - UnitNine;
         for (int k = 0; k < 4; k++) begin
            if (SymbolWidth'(k) < nz) begin
               if (cnt < CountWidth'(MaxDigits)) begin
                  dig[cnt[$clog2(MaxDigits)-1:0]] = '0;
                  cnt = cnt + 1'b1;
               end
               any_emitted_in = 1'b1;
            end
         end
         last_unit_in = SymMyriad;
         deferred_in = '0;
      end
      at_start_in = 1'b0;

      pkt.bare = 1'b0;
      if (last) begin
         // trailing zeros, held digit takes the final place
         if (last_unit_in >= SymTen) begin
            nz = last_unit_in - UnitNine;
            for (int k = 0; k < 4; k++) begin
               if (SymbolWidth'(k) < nz) begin
                  if (cnt < CountWidth'(MaxDigits)) begin
                     dig[cnt[$clog2(MaxDigits)-1:0]] = '0;
                     cnt = cnt + 1'b1;
                  end
                  any_emitted_in = 1'b1;
               end
            end
            if (deferred_in != '0 && cnt != '0)
               dig[$clog2(MaxDigits)'(cnt - 1'b1)] = deferred_in;
         end
         if (!any_emitted_in) begin
            dig[0] = '0;
            cnt = cnt + 1'b1;
         end
         if (cnt == '0) begin
            pkt.bare = 1'b1;
            cnt = CountWidth'(1);
         end
         zero_pending_in = 1'b0;
         at_start_in = 1'b1;
         last_unit_in = '0;
         deferred_in = '0;
         any_emitted_in = 1'b0;
      end
      pkt.digits = dig;
      pkt.count = cnt;
      pkt.last = last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         zero_pending_ff <= 1'b0;
         at_start_ff <= 1'b1;
         last_unit_ff <= '0;
         deferred_ff <= '0;
         any_emitted_ff <= 1'b0;
      end else if (step) begin
         zero_pending_ff <= zero_pending_in;
         at_start_ff <= at_start_in;
         last_unit_ff <= last_unit_in;
         deferred_ff <= deferred_in;
         any_emitted_ff <= any_emitted_in;
      end
   end

   a_unit_legal: assert property (@(posedge clock) disable iff (reset)
      last_unit_ff == '0 || (last_unit_ff >= SymTen && last_unit_ff <= SymMyriad))
      else $error("unit register out of range");
   a_start_clean: assert property (@(posedge clock) disable iff (reset)
      at_start_ff |-> (!zero_pending_ff && last_unit_ff == '0 && !any_emitted_ff))
      else $error("numeral start with stale state");

endmodule

@@ hw/rtl/cntd_emit.sv @@
// Result register: holds one step's digits and shifts them out a word a cycle while rsp_stall is low.
// Depends on cntd_pkg.
module cntd_emit (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load,
   input  cntd_pkg::pkt_type      pkt,
   output logic                   free,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output cntd_pkg::rsp_word_type rsp_word
);
   import cntd_pkg::*;

   logic [MaxDigits-1:0][DigitWidth-1:0] digits_ff;
   logic [CountWidth-1:0]                remain_ff;
   logic                                 last_ff;
   logic                                 bare_ff;
   logic                                 take;

   assign rsp_valid = remain_ff != '0;
   assign take = rsp_valid && !rsp_stall;
   // free when empty or the final word leaves this cycle
   assign free = !rsp_valid || (take && remain_ff == CountWidth'(1));

   assign rsp_word.digit = digits_ff[0];
   assign rsp_word.digit_valid = !bare_ff;
   assign rsp_word.end_of_number = last_ff && remain_ff == CountWidth'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         remain_ff <= '0;
      end else if (load) begin
         remain_ff <= pkt.count;
      end else if (take) begin
         remain_ff <= remain_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         digits_ff <= pkt.digits;
         last_ff <= pkt.last;
         bare_ff <= pkt.bare;
      end else if (take) begin
         digits_ff <= {DigitWidth'(0), digits_ff[MaxDigits-1:1]};
      end
   end

   a_remain_bound: assert property (@(posedge clock) disable iff (reset)
      remain_ff <= CountWidth'(MaxDigits))
      else $error("result count overflow");
   a_bare_single: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && bare_ff) |-> (remain_ff == CountWidth'(1) && last_ff))
      else $error("end marker not alone");

endmodule

@@ hw/rtl/chinese_numeral_to_decimal_top.sv @@
// Top level of the Chinese numeral to decimal converter.
// Depends on cntd_pkg, cntd_core and cntd_emit.
//
// Takes one numeral symbol per word (0-9 digits, 10 ten, 11 hundred,
// 12 thousand, 13 ten-thousand; last_symbol closes the numeral) and returns the
// decimal digits of the numeral as rsp words, one digit per word, most
// significant first. end_of_number marks the final word of a numeral; a word
// with digit_valid low is a bare end marker for a closing symbol that adds no
// digit. A symbol word passes an input register, then the digit expansion
// logic and the numeral state update into the result register, which hands
// out its digits one per cycle while rsp_stall is low. A symbol yields up to
// 8 digits; a symbol that yields no rsp word loads nothing into the result
// register. With the result side draining freely a new symbol is taken while
// the result register still shows the final digit of the previous symbol, so
// the sustained rate is set by the number of digits per symbol. The first
// digit of an accepted symbol passes the input register and the result
// register. Codes 14 and 15 match no numeral: they drop a held zero and
// produce nothing unless they close the numeral.
module chinese_numeral_to_decimal_top (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  cntd_pkg::req_word_type req_word,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output cntd_pkg::rsp_word_type rsp_word
);
   import cntd_pkg::*;

   req_word_type in_word_ff;
   logic         in_valid_ff, in_valid_in;
   logic         accept;
   logic         advance;
   logic         emit_free;
   pkt_type      pkt;

   // advance the held symbol once the result register can take its digits
   assign advance = in_valid_ff && emit_free;
   assign req_stall = in_valid_ff && !emit_free;
   assign accept = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   // hold the payload until it advances
   always_ff @(posedge clock) begin
      if (accept) in_word_ff <= req_word;
   end

   cntd_core u_core (
      .clock (clock),
      .reset (reset),
      .step  (advance),
      .word  (in_word_ff),
      .pkt   (pkt)
   );

   cntd_emit u_emit (
      .clock     (clock),
      .reset     (reset),
      .load      (advance && pkt.count != '0),
      .pkt       (pkt),
      .free      (emit_free),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   a_stall_needs_word: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff)
      else $error("stall with empty input register");
   a_idle_no_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("stall while result register empty");
   a_accept_held: assert property (@(posedge clock) disable iff (reset)
      accept |=> in_valid_ff)
      else $error("accepted symbol lost");

endmodule
